// ===== rtl/nctg_pkg.sv =====
// shared constants, types and elaboration-time tables for the note-controlled sine tone generator
// holds the per-note phase increment table and the quarter-wave sine table
// no dependencies
package nctg_pkg;

	localparam int PHASE_BITS     = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int NOTE_COUNT     = 128;
	localparam int NOTE_BITS      = 7;
	localparam int NOTE_IDX_BITS  = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
	localparam int Q_BITS         = SINE_ADDR_BITS - 2;
	localparam int QSIZE          = 1 << Q_BITS;
	localparam int MAG_BITS       = 31;
	localparam int AMP_BITS       = 15;
	localparam int SAMPLE_BITS    = 16;
	localparam int PROD_BITS      = MAG_BITS + AMP_BITS;
	localparam int FRAC_BITS      = 30;

	// input word kinds on the cmd port
	localparam logic CMD_CTRL = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [AMP_BITS-1:0] AMP_RESET = AMP_BITS'(16000);

	localparam int RATE_HZ = 44100;
	localparam int BASE_HZ = 440;

	// 2^(k/12) in unsigned q1.31
	localparam logic [31:0] SEMITONE_Q31 [12] = '{
		32'd2147483648, 32'd2275179670, 32'd2410468894, 32'd2553802833,
		32'd2705659852, 32'd2866546760, 32'd3037000500, 32'd3217589947,
		32'd3408917802, 32'd3611622603, 32'd3826380858, 32'd4053909305
	};

	// odd taylor terms of sin(pi/2*z) in q30
	localparam logic [63:0] COEF1 = 64'd1686629713;
	localparam logic [63:0] COEF3 = 64'd693598668;
	localparam logic [63:0] COEF5 = 64'd85569306;
	localparam logic [63:0] COEF7 = 64'd5026995;
	localparam logic [63:0] COEF9 = 64'd172272;
	localparam logic [63:0] Q30_ONE = 64'd1 << FRAC_BITS;

	typedef logic [MAG_BITS-1:0] qs_table_t [QSIZE];
	typedef logic [PHASE_BITS-1:0] inc_table_t [NOTE_COUNT];

	typedef struct packed {
		logic                      valid;
		logic                      gate;
		logic [SINE_ADDR_BITS-1:0] addr;
	} tick_t;

	// 64-bit wrapping arithmetic, same truncations at every product
	function automatic logic [63:0] quarter_sine(input logic [63:0] z);
		logic [63:0] z2;
		logic [63:0] p;
		z2 = (z * z) >> FRAC_BITS;
		p  = COEF9;
		p  = COEF7 - ((z2 * p) >> FRAC_BITS);
		p  = COEF5 - ((z2 * p) >> FRAC_BITS);
		p  = COEF3 - ((z2 * p) >> FRAC_BITS);
		p  = COEF1 - ((z2 * p) >> FRAC_BITS);
		p  = (z * p) >> FRAC_BITS;
		return (p > Q30_ONE) ? Q30_ONE : p;
	endfunction

	function automatic qs_table_t build_qs_table();
		qs_table_t t;
		for (int i = 0; i < QSIZE; i++) begin
			t[i] = MAG_BITS'(quarter_sine(64'(i) << (FRAC_BITS - Q_BITS)));
		end
		return t;
	endfunction

	// floor(440 * 2^(k/12) * 2^(PHASE_BITS + oct) / 44100) mod 2^PHASE_BITS
	function automatic inc_table_t build_inc_table();
		inc_table_t  t;
		logic [95:0] a;
		logic [95:0] q;
		int          s;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			a = 96'(BASE_HZ) * 96'(SEMITONE_Q31[n % 12]);
			s = PHASE_BITS + (n / 12) - 31;
			if (s <= 0) begin
				q = (a >> (-s)) / 96'(RATE_HZ);
			end else begin
				q = (a << s) / 96'(RATE_HZ);
			end
			t[n] = PHASE_BITS'(q);
		end
		return t;
	endfunction

	localparam qs_table_t  QS_TABLE  = build_qs_table();
	localparam inc_table_t INC_TABLE = build_inc_table();
	localparam logic [MAG_BITS-1:0] QS_PEAK =
		MAG_BITS'(quarter_sine(64'(QSIZE) << (FRAC_BITS - Q_BITS)));

endpackage

// ===== rtl/nctg_osc.sv =====
// oscillator front end: note and gate state, phase accumulator, tick register
// depends on nctg_pkg
module nctg_osc (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [7:0]            ctrl_byte,
	input  logic                  advance,
	output nctg_pkg::tick_t       tick
);

	logic [nctg_pkg::PHASE_BITS-1:0]     phase_q;
	logic [nctg_pkg::NOTE_BITS-1:0]      note_q;
	logic                                gate_q;
	logic                                valid_s1;
	logic                                gate_s1;
	logic [nctg_pkg::SINE_ADDR_BITS-1:0] addr_s1;
	logic                                in_acc;
	logic                                ctrl_acc;
	logic                                tick_acc;
	logic [nctg_pkg::NOTE_BITS-1:0]      note_new;
	logic [nctg_pkg::PHASE_BITS-1:0]     inc;

	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;
	assign ctrl_acc = in_acc && (cmd == nctg_pkg::CMD_CTRL);
	assign tick_acc = in_acc && (cmd == nctg_pkg::CMD_TICK);

	always_comb begin
		if ({1'b0, ctrl_byte[6:0]} >= 8'(nctg_pkg::NOTE_COUNT)) begin
			note_new = nctg_pkg::NOTE_BITS'(nctg_pkg::NOTE_COUNT - 1);
		end else begin
			note_new = ctrl_byte[6:0];
		end
	end

	assign inc = nctg_pkg::INC_TABLE[note_q[nctg_pkg::NOTE_IDX_BITS-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			note_q  <= '0;
			gate_q  <= 1'b0;
		end else if (ctrl_acc) begin
			gate_q <= ctrl_byte[7];
			if (note_new != note_q) begin
				note_q  <= note_new;
				phase_q <= '0;
			end
		end else if (tick_acc) begin
			phase_q <= phase_q + inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// sample uses the phase before this tick's increment
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			gate_s1 <= gate_q;
			addr_s1 <= phase_q[nctg_pkg::PHASE_BITS-1 -: nctg_pkg::SINE_ADDR_BITS];
		end
	end

	assign tick = '{valid: valid_s1, gate: gate_s1, addr: addr_s1};

	a_note_change_clears_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl_acc && (note_new != note_q) |=> phase_q == '0)
		else $error("phase not cleared on note change");

	a_tick_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> valid_s1)
		else $error("accepted tick lost before stage 1");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage");

endmodule

// ===== rtl/nctg_shaper.sv =====
// waveform shaper: quarter-wave fold, sine table lookup, amplitude scale, output register
// depends on nctg_pkg; holds the amplitude register
module nctg_shaper (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  nctg_pkg::tick_t                        tick,
	output logic                                   advance,
	input  logic                                   cfg_we,
	input  logic [nctg_pkg::AMP_BITS-1:0]          cfg_wdata,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [nctg_pkg::SAMPLE_BITS-1:0] sample
);

	logic [nctg_pkg::AMP_BITS-1:0]           amp_q;
	logic                                    out_valid_q;
	logic signed [nctg_pkg::SAMPLE_BITS-1:0] sample_q;
	logic                                    take;
	logic [1:0]                              quad;
	logic [nctg_pkg::Q_BITS-1:0]             j;
	logic [nctg_pkg::Q_BITS:0]               pos;
	logic [nctg_pkg::MAG_BITS-1:0]           mag;
	logic [nctg_pkg::PROD_BITS-1:0]          prod;
	logic [nctg_pkg::SAMPLE_BITS-1:0]        scaled;
	logic [nctg_pkg::SAMPLE_BITS-1:0]        result;

	assign advance = !out_valid_q || !out_stall;
	assign take    = tick.valid && advance;

	assign quad = tick.addr[nctg_pkg::SINE_ADDR_BITS-1 -: 2];
	assign j    = tick.addr[nctg_pkg::Q_BITS-1:0];

	// odd quadrants run the quarter wave backwards
	assign pos = quad[0] ? ((nctg_pkg::Q_BITS + 1)'(nctg_pkg::QSIZE) - {1'b0, j})
	                     : {1'b0, j};

	always_comb begin
		if (pos[nctg_pkg::Q_BITS]) begin
			mag = nctg_pkg::QS_PEAK;
		end else begin
			mag = nctg_pkg::QS_TABLE[pos[nctg_pkg::Q_BITS-1:0]];
		end
	end

	assign prod   = nctg_pkg::PROD_BITS'(mag) * nctg_pkg::PROD_BITS'(amp_q);
	assign scaled = nctg_pkg::SAMPLE_BITS'(prod >> nctg_pkg::FRAC_BITS);

	always_comb begin
		if (!tick.gate) begin
			result = '0;
		end else if (quad[1]) begin
			result = -scaled;
		end else begin
			result = scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= nctg_pkg::AMP_RESET;
		end else if (cfg_we) begin
			amp_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_q <= signed'(result);
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	a_gate_off_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && !tick.gate |=> sample_q == '0)
		else $error("nonzero word with gate off");

	a_no_full_scale_negative: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> sample_q != {1'b1, {(nctg_pkg::SAMPLE_BITS-1){1'b0}}})
		else $error("sample out of symmetric range");

	a_take_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("tick taken but no output word");

endmodule

// ===== rtl/note_controlled_sine_tone_generator.sv =====
// a tick word's sample word passes the stage 1 register, then the output register; out_stall can hold it between them
// throughput: one word per cycle while in_stall is low, control bytes and ticks alike; control bytes give no output
// the per-cycle path is one table lookup plus a 31x15 multiply after the stage 1 register
// reset: phase 0, note 0 (440 Hz), gate off, amplitude 16000, both pipeline stages empty
// depends on nctg_pkg, nctg_osc, nctg_shaper
module note_controlled_sine_tone_generator (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    cmd,
	input  logic [7:0]                              ctrl_byte,
	input  logic                                    cfg_we,
	input  logic [nctg_pkg::AMP_BITS-1:0]           cfg_wdata,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic signed [nctg_pkg::SAMPLE_BITS-1:0] sample
);

	nctg_pkg::tick_t tick;
	logic            advance;

	nctg_osc u_osc (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.ctrl_byte (ctrl_byte),
		.advance   (advance),
		.tick      (tick)
	);

	nctg_shaper u_shaper (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.advance   (advance),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

endmodule
